>>> sv/ste_pkg.sv
// Shared types, codes and default sizes of the sparse-table range engine.
package ste_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the stream payloads.
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 10;
    localparam int S_TDATA_W = 56;

    // Request kinds carried in s_tuser.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // States of the table build sequencer.
    typedef enum logic [1:0] {
        BLD_IDLE,
        BLD_RUN,
        BLD_GAP
    } bld_state_t;

    // Control and status from the build sequencer to the top level.
    typedef struct packed {
        logic busy;
        logic rd_en;
        logic wr_en;
    } bld_ctl_t;

endpackage

>>> sv/ste_table.sv
// Level table memory: one write port and two registered read ports.
module ste_table #(
    parameter int W     = 32,
    parameter int AW    = 14,
    parameter int DEPTH = 11264
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [W-1:0]  rd_data_a,
    output logic [W-1:0]  rd_data_b
);

    logic [W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Both read ports hold their data until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> sv/ste_build.sv
// Build sequencer: fills each level above level 0 of the table from the level below.
module ste_build #(
    parameter int W     = 32,
    parameter int CNT_W = 11,
    parameter int IDX_W = 10,
    parameter int AL_W  = 4,
    parameter int LVL_W = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    mode,
    input  logic [CNT_W-1:0]        count,
    input  logic [W-1:0]            rd_data_a,
    input  logic [W-1:0]            rd_data_b,
    output ste_pkg::bld_ctl_t       ctl,
    output logic [AL_W+IDX_W-1:0]   rd_addr_a,
    output logic [AL_W+IDX_W-1:0]   rd_addr_b,
    output logic [AL_W+IDX_W-1:0]   wr_addr,
    output logic [W-1:0]            wr_data
);

    localparam int AW = AL_W + IDX_W;

    ste_pkg::bld_state_t state_reg, state_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic                mode_reg;

    logic [CNT_W:0]      span;
    logic [CNT_W:0]      half;
    logic                level_ok;
    logic                level_end;
    logic [LVL_W-1:0]    lvl_below;
    logic [CNT_W:0]      idx_b;

    // Span of one entry of the current level and of the level below.
    assign span      = (CNT_W+1)'(1) << lvl_reg;
    assign half      = span >> 1;
    assign level_ok  = span <= {1'b0, count};
    assign level_end = (CNT_W+1)'(idx_reg) == ({1'b0, count} - span);
    assign lvl_below = lvl_reg - LVL_W'(1);
    assign idx_b     = (CNT_W+1)'(idx_reg) + half;

    assign rd_addr_a = {lvl_below[AL_W-1:0], idx_reg};
    assign rd_addr_b = {lvl_below[AL_W-1:0], idx_b[IDX_W-1:0]};
    assign wr_addr   = wr_addr_reg;

    // The entry written is the better of the two entries read in the cycle before.
    always_comb begin
        logic a_less;
        a_less = $signed(rd_data_a) < $signed(rd_data_b);
        if (mode_reg) begin
            wr_data = a_less ? rd_data_b : rd_data_a;
        end else begin
            wr_data = a_less ? rd_data_a : rd_data_b;
        end
    end

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ste_pkg::BLD_IDLE;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg     <= lvl_next;
        idx_reg     <= idx_next;
        wr_addr_reg <= wr_addr_next;
        if (start) begin
            mode_reg <= mode;
        end
    end

    // Next state: one read pair per cycle, and the gap state between levels so the
    // last write of a level lands before the next level reads it.
    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        idx_next     = idx_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        ctl.rd_en    = 1'b0;
        ctl.wr_en    = wr_pend_reg;
        ctl.busy     = state_reg != ste_pkg::BLD_IDLE;
        unique case (state_reg)
            ste_pkg::BLD_IDLE: begin
                if (start) begin
                    state_next = ste_pkg::BLD_RUN;
                    lvl_next   = LVL_W'(1);
                    idx_next   = '0;
                end
            end
            ste_pkg::BLD_RUN: begin
                if (!level_ok) begin
                    state_next = ste_pkg::BLD_IDLE;
                end else begin
                    ctl.rd_en    = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = {lvl_reg[AL_W-1:0], idx_reg};
                    if (level_end) begin
                        state_next = ste_pkg::BLD_GAP;
                        lvl_next   = lvl_reg + LVL_W'(1);
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ste_pkg::BLD_GAP: begin
                state_next = ste_pkg::BLD_RUN;
            end
            default: begin
                state_next = ste_pkg::BLD_IDLE;
            end
        endcase
    end

endmodule

>>> sv/sparse_table_range_extreme_core.sv
// Sparse-table range minimum/maximum engine, top level.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tuser func, s_tlast last,
//          |           |                     | s_tdata value, from, to
//  m_      | out       | m_tvalid / m_tready | m_tdata range_best, m_tuser error
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data max_mode
//
// Loads and queries are accepted one per cycle while s_tready is high; a query result
// passes through the registered table read and then the output register.
// A load flagged last starts the build, which fills the levels in turn with a gap
// state between levels; s_tready stays low while it runs.
// Output stalls hold one query in the read stage and then block new requests.
// Reset clears the load counters and the valid flags and selects max mode; the table itself is not cleared.
module sparse_table_range_extreme_core #(
    parameter int MAX_ENTRIES = ste_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: value [31:0], from_index [41:32], to_index [51:42], zero pad
    input  logic [ste_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: range_best [31:0]
    output logic [ste_pkg::DATA_W-1:0]    m_tdata,
    // m_tuser: error
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

    localparam int LEVELS = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int AL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int AW     = AL_W + IDX_W;
    localparam int DEPTH  = LEVELS * (2 ** IDX_W);
    localparam int LEN_W  = ste_pkg::INDEX_W + 1;
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Position of the highest set bit of a range length.
    function automatic logic [3:0] floor_log2(input logic [LEN_W-1:0] x);
        logic [3:0] lg;
        lg = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (x[i]) begin
                lg = 4'(i);
            end
        end
        return lg;
    endfunction

    logic                   max_mode_reg;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ready_reg, ready_next;
    logic                   q1_vld_reg, q1_vld_next;
    logic                   q1_err_reg;
    logic                   m_tvalid_reg;
    logic [ste_pkg::DATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   s_acc;
    logic                   is_load;
    logic                   advance;
    logic                   bld_start;
    ste_pkg::bld_ctl_t      bld;

    logic [ste_pkg::INDEX_W-1:0] q_from;
    logic [ste_pkg::INDEX_W-1:0] q_to;
    logic [LEN_W-1:0]       q_len;
    logic [3:0]             q_lg;
    logic [LEN_W-1:0]       q_b;
    logic                   q_bad;

    logic [CNT_W-1:0]       pos_eff;
    logic                   has_room;
    logic [CNT_W-1:0]       pos_new;

    logic                   tb_wr_en;
    logic [AW-1:0]          tb_wr_addr;
    logic [VALUE_WIDTH-1:0] tb_wr_data;
    logic                   tb_rd_en;
    logic [AW-1:0]          tb_rd_addr_a;
    logic [AW-1:0]          tb_rd_addr_b;
    logic [VALUE_WIDTH-1:0] rd_data_a;
    logic [VALUE_WIDTH-1:0] rd_data_b;
    logic [AW-1:0]          bld_rd_addr_a;
    logic [AW-1:0]          bld_rd_addr_b;
    logic [AW-1:0]          bld_wr_addr;
    logic [VALUE_WIDTH-1:0] bld_wr_data;
    logic [VALUE_WIDTH-1:0] best;

    // Handshakes.
    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = !bld.busy && (advance || !q1_vld_reg);
    assign s_acc     = s_tvalid && s_tready;
    assign is_load   = s_tuser == ste_pkg::FUNC_LOAD;
    assign bld_start = s_acc && is_load && s_tlast;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            max_mode_reg <= cfg_data;
        end
    end

    // Query decode: validity, level and the two overlapping entries.
    assign q_from = s_tdata[41:32];
    assign q_to   = s_tdata[51:42];
    assign q_len  = {1'b0, q_to} - {1'b0, q_from} + LEN_W'(1);
    assign q_lg   = floor_log2(q_len);
    assign q_b    = {1'b0, q_to} + LEN_W'(1) - (LEN_W'(1) << q_lg);
    assign q_bad  = !ready_reg || (q_from > q_to) ||
                    (CMP_W'(q_to) >= CMP_W'(count_reg));

    // Load position: a load after a finished build starts a new data set.
    assign pos_eff  = ready_reg ? '0 : pos_reg;
    assign has_room = pos_eff < CNT_W'(MAX_ENTRIES);
    assign pos_new  = pos_eff + CNT_W'(has_room);

    always_comb begin
        pos_next   = pos_reg;
        count_next = count_reg;
        ready_next = ready_reg;
        if (s_acc && is_load) begin
            pos_next = pos_new;
            if (s_tlast) begin
                count_next = pos_new;
                ready_next = 1'b1;
            end else begin
                ready_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    // Table port selection between the builder and the request stream.
    always_comb begin
        if (bld.busy) begin
            tb_wr_en     = bld.wr_en;
            tb_wr_addr   = bld_wr_addr;
            tb_wr_data   = bld_wr_data;
            tb_rd_en     = bld.rd_en;
            tb_rd_addr_a = bld_rd_addr_a;
            tb_rd_addr_b = bld_rd_addr_b;
        end else begin
            tb_wr_en     = s_acc && is_load && has_room;
            tb_wr_addr   = {AL_W'(0), pos_eff[IDX_W-1:0]};
            tb_wr_data   = VALUE_WIDTH'(signed'(s_tdata[ste_pkg::DATA_W-1:0]));
            tb_rd_en     = s_acc && !is_load && !q_bad;
            tb_rd_addr_a = {AL_W'(q_lg), IDX_W'(q_from)};
            tb_rd_addr_b = {AL_W'(q_lg), IDX_W'(q_b)};
        end
    end

    ste_table #(
        .W     (VALUE_WIDTH),
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (tb_wr_en),
        .wr_addr   (tb_wr_addr),
        .wr_data   (tb_wr_data),
        .rd_en     (tb_rd_en),
        .rd_addr_a (tb_rd_addr_a),
        .rd_addr_b (tb_rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ste_build #(
        .W     (VALUE_WIDTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W),
        .AL_W  (AL_W),
        .LVL_W (LVL_W)
    ) u_build (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (bld_start),
        .mode      (max_mode_reg),
        .count     (count_next),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .ctl       (bld),
        .rd_addr_a (bld_rd_addr_a),
        .rd_addr_b (bld_rd_addr_b),
        .wr_addr   (bld_wr_addr),
        .wr_data   (bld_wr_data)
    );

    // Read stage: one query waits here for its table data.
    always_comb begin
        q1_vld_next = q1_vld_reg;
        if (s_acc && !is_load) begin
            q1_vld_next = 1'b1;
        end else if (advance) begin
            q1_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_vld_reg <= 1'b0;
        end else begin
            q1_vld_reg <= q1_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !is_load) begin
            q1_err_reg <= q_bad;
        end
    end

    // Final combine uses the mode in force now.
    always_comb begin
        logic a_less;
        a_less = $signed(rd_data_a) < $signed(rd_data_b);
        if (max_mode_reg) begin
            best = a_less ? rd_data_b : rd_data_a;
        end else begin
            best = a_less ? rd_data_a : rd_data_b;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= q1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && q1_vld_reg) begin
            m_tuser_reg <= q1_err_reg;
            m_tdata_reg <= q1_err_reg ? '0 : ste_pkg::DATA_W'(signed'(best));
        end
    end

    // An error result always carries zero data.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero data");

    // The builder never writes in a cycle that accepts a request.
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        bld.wr_en |-> !s_acc)
        else $error("build write collides with an accepted request");

    // A closing load always starts the build sequencer.
    a_bld_start: assert property (@(posedge aclk) disable iff (!aresetn)
        bld_start |=> bld.busy)
        else $error("build did not start after the last load");

    // An accepted query always occupies the read stage next cycle.
    a_q_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !is_load |=> q1_vld_reg)
        else $error("accepted query lost before the read stage");

endmodule
